FILE: design/psp_pkg.sv
// shared types, constants and functions of the spherical point projection
`default_nettype none

package psp_pkg;

	localparam int COORD_W   = 18;
	localparam int SQ_W      = 36;
	localparam int RAD_W     = 60;
	localparam int ROOT_W    = 30;
	localparam int REM_W     = 34;
	localparam int R16_W     = 26;
	localparam int SQ_CELLS  = RAD_W / 2;
	localparam int RANGE_W   = 18;
	localparam int RADIUS_W  = 16;

	localparam int CORDIC_W  = 34;
	localparam int ANG_W     = 20;
	localparam int PRESCALE  = 12;
	localparam int AZ_W      = 16;
	localparam int POL_W     = 15;
	localparam int PI_Q13    = 25736;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 20'sd102944;

	localparam int PROD_W    = 34;
	localparam int DIV_CELLS = 17;
	localparam int DIV_REM_W = 44;
	localparam int QUO_W     = 17;
	localparam int SURF_W    = 17;
	localparam int CLOSE_W   = 19;

	localparam int PADDR_W   = 3;
	localparam logic [PADDR_W-1:0] REG_SURFACE_RADIUS = 3'd0;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd2048;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_state_t;

	typedef struct packed {
		logic signed [CORDIC_W-1:0] px;
		logic signed [CORDIC_W-1:0] py;
		logic signed [ANG_W-1:0]    ang;
	} cordic_vec_t;

	typedef struct packed {
		logic [DIV_REM_W-1:0] rem;
		logic [R16_W-1:0]     den;
		logic [QUO_W-1:0]     quo;
		logic                 neg;
	} div_state_t;

	function automatic logic signed [ANG_W-1:0] atan_q16(input int idx);
		case (idx)
			0:  return 20'sd51472;
			1:  return 20'sd30386;
			2:  return 20'sd16055;
			3:  return 20'sd8150;
			4:  return 20'sd4091;
			5:  return 20'sd2047;
			6:  return 20'sd1024;
			7:  return 20'sd512;
			8:  return 20'sd256;
			9:  return 20'sd128;
			10: return 20'sd64;
			11: return 20'sd32;
			12: return 20'sd16;
			13: return 20'sd8;
			14: return 20'sd4;
			15: return 20'sd2;
			16: return 20'sd1;
			default: return '0;
		endcase
	endfunction

endpackage

`default_nettype wire

FILE: design/psp_if.sv
// valid/ready channels for input points and projection results
`default_nettype none

interface psp_point_if;
	logic                valid;
	logic                ready;
	logic signed [17:0]  point_x;
	logic signed [17:0]  point_y;
	logic signed [17:0]  point_z;

	modport source (output valid, output point_x, output point_y, output point_z,
		input ready);
	modport sink (input valid, input point_x, input point_y, input point_z,
		output ready);
endinterface

interface psp_proj_if;
	logic                valid;
	logic                ready;
	logic signed [15:0]  azimuth;
	logic        [14:0]  polar_angle;
	logic        [17:0]  range;
	logic signed [18:0]  closeness;
	logic signed [16:0]  surface_x;
	logic signed [16:0]  surface_y;
	logic signed [16:0]  surface_z;
	logic                degenerate;

	modport source (output valid, output azimuth, output polar_angle, output range,
		output closeness, output surface_x, output surface_y, output surface_z,
		output degenerate, input ready);
	modport sink (input valid, input azimuth, input polar_angle, input range,
		input closeness, input surface_x, input surface_y, input surface_z,
		input degenerate, output ready);
endinterface

`default_nettype wire

FILE: design/point_spherical_projection_top.sv
// top level of the cartesian to spherical point projection
//
// point channel: one lidar point (x, y, z) per transaction, 1/256 m units.
// proj channel: one result per point: range, azimuth, polar angle (Q3.13 rad),
// closeness to the sphere and the point projected onto the sphere.
// apb port: register 0 holds the sphere radius (reset 2048); the user must write it
// only while no point is in flight, which the block itself does not enforce.
// throughput: one point per clock, back to back, while proj is ready.
// path from acceptance to the result on proj: the squares and sums registers,
// the 30-cell square root row (one result bit per cell), then the longer of
// the cordic cell row and the 17-cell divider row, then the output register.
// a point at the origin gives the degenerate flag with zero angles and a
// zero surface point.
// reset empties the pipeline and restores the radius register.
// when proj is stalled with a result waiting, every stage holds and point
// ready drops until the result is taken.
`default_nettype none

module point_spherical_projection_top import psp_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	psp_point_if.sink               point,
	psp_proj_if.source              proj,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

	localparam int CORDIC_LEN = CORDIC_STAGES + 2;
	localparam int DIV_LEN    = DIV_CELLS + 2;
	localparam int POST_LEN   = (CORDIC_LEN > DIV_LEN) ? CORDIC_LEN : DIV_LEN;

	function automatic cordic_vec_t cordic_pre(input logic signed [CORDIC_W-1:0] px,
		input logic signed [CORDIC_W-1:0] py);
		cordic_vec_t r;
		r.px  = px;
		r.py  = py;
		r.ang = '0;
		if (px[CORDIC_W-1]) begin
			if (!py[CORDIC_W-1]) begin
				r.px  = py;
				r.py  = -px;
				r.ang = HALF_PI_Q16;
			end else begin
				r.px  = -py;
				r.py  = px;
				r.ang = -HALF_PI_Q16;
			end
		end
		return r;
	endfunction

	function automatic logic [POL_W-1:0] round_angle(input logic signed [ANG_W-1:0] a);
		logic [ANG_W-1:0] ab;
		logic [ANG_W-1:0] m;
		ab = a[ANG_W-1] ? ANG_W'(-a) : ANG_W'(a);
		m  = (ab + ANG_W'(4)) >> 3;
		if (m > ANG_W'(PI_Q13)) m = ANG_W'(PI_Q13);
		return POL_W'(m);
	endfunction

	// configuration
	logic [RADIUS_W-1:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (psel && penable && pwrite && paddr == REG_SURFACE_RADIUS) begin
			radius_q <= pwdata[RADIUS_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == REG_SURFACE_RADIUS) ? {16'b0, radius_q} : '0;

	// pipeline advance
	logic out_valid_q;
	logic adv;

	assign adv         = !out_valid_q || proj.ready;
	assign point.ready = adv;

	// squares
	logic                      v_s1, deg_s1;
	logic signed [COORD_W-1:0] x_s1, y_s1, z_s1;
	logic        [SQ_W-1:0]    sqx_s1, sqy_s1, sqz_s1;
	logic signed [SQ_W-1:0]    px2, py2, pz2;

	assign px2 = SQ_W'(point.point_x * point.point_x);
	assign py2 = SQ_W'(point.point_y * point.point_y);
	assign pz2 = SQ_W'(point.point_z * point.point_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= point.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= point.point_x;
			y_s1   <= point.point_y;
			z_s1   <= point.point_z;
			deg_s1 <= (point.point_x == '0) && (point.point_y == '0) && (point.point_z == '0);
			sqx_s1 <= $unsigned(px2);
			sqy_s1 <= $unsigned(py2);
			sqz_s1 <= $unsigned(pz2);
		end
	end

	// sums
	logic                      v_s2, deg_s2;
	logic signed [COORD_W-1:0] x_s2, y_s2, z_s2;
	logic        [SQ_W-1:0]    sxy_s2, ssum_s2;
	logic        [SQ_W-1:0]    sxy_c;

	assign sxy_c = sqx_s1 + sqy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			z_s2    <= z_s1;
			deg_s2  <= deg_s1;
			sxy_s2  <= sxy_c;
			ssum_s2 <= sxy_c + sqz_s1;
		end
	end

	// square root rows: range (scaled by 256) and rho (scaled by 4096)
	sqrt_state_t sa [SQ_CELLS+1];
	sqrt_state_t sb [SQ_CELLS+1];

	assign sa[0].rad  = RAD_W'({ssum_s2, 16'b0});
	assign sa[0].rem  = '0;
	assign sa[0].root = '0;
	assign sb[0].rad  = {sxy_s2, 24'b0};
	assign sb[0].rem  = '0;
	assign sb[0].root = '0;

	generate
		for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
			psp_sqrt_cell u_cell_a (.clk(clk), .en(adv), .d(sa[i]), .q(sa[i+1]));
			psp_sqrt_cell u_cell_b (.clk(clk), .en(adv), .d(sb[i]), .q(sb[i+1]));
		end
	endgenerate

	logic                      sq_v, sq_deg;
	logic signed [COORD_W-1:0] sq_c [3];
	logic        [R16_W-1:0]   r16;
	logic        [ROOT_W-1:0]  rho;

	psp_delay #(.W(2 + 3 * COORD_W), .DEPTH(SQ_CELLS)) u_sq_side (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.d({v_s2, deg_s2, x_s2, y_s2, z_s2}),
		.q({sq_v, sq_deg, sq_c[0], sq_c[1], sq_c[2]})
	);

	assign r16 = sa[SQ_CELLS].root[R16_W-1:0];
	assign rho = sb[SQ_CELLS].root;

	// angle cordic rows
	cordic_vec_t ca [CORDIC_STAGES+1];
	cordic_vec_t cp [CORDIC_STAGES+1];
	cordic_vec_t ca_s3, cp_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			ca_s3 <= cordic_pre(CORDIC_W'(sq_c[0]) <<< PRESCALE,
				CORDIC_W'(sq_c[1]) <<< PRESCALE);
			cp_s3 <= cordic_pre(CORDIC_W'(sq_c[2]) <<< PRESCALE,
				$signed(CORDIC_W'(rho)));
		end
	end

	assign ca[0] = ca_s3;
	assign cp[0] = cp_s3;

	generate
		for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
			psp_cordic_cell #(.IDX(i)) u_cell_a (.clk(clk), .en(adv), .d(ca[i]), .q(ca[i+1]));
			psp_cordic_cell #(.IDX(i)) u_cell_p (.clk(clk), .en(adv), .d(cp[i]), .q(cp[i+1]));
		end
	endgenerate

	logic signed [AZ_W-1:0]  az_rnd_q;
	logic        [POL_W-1:0] pol_rnd_q;
	logic        [POL_W-1:0] az_mag;

	assign az_mag = round_angle(ca[CORDIC_STAGES].ang);

	always_ff @(posedge clk) begin
		if (adv) begin
			az_rnd_q  <= ca[CORDIC_STAGES].ang[ANG_W-1] ? -$signed({1'b0, az_mag})
				: $signed({1'b0, az_mag});
			pol_rnd_q <= cp[CORDIC_STAGES].ang[ANG_W-1] ? '0
				: round_angle(cp[CORDIC_STAGES].ang);
		end
	end

	logic signed [AZ_W-1:0]  az_al;
	logic        [POL_W-1:0] pol_al;

	psp_delay #(.W(AZ_W + POL_W), .DEPTH(POST_LEN - CORDIC_LEN)) u_ang_align (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.d({az_rnd_q, pol_rnd_q}),
		.q({az_al, pol_al})
	);

	// divider rows: round(radius * c * 256 / r16)
	logic [QUO_W-1:0] quo_al [3];
	logic             neg_al [3];

	generate
		for (genvar c = 0; c < 3; c++) begin : g_div
			logic       [COORD_W-1:0] mag;
			logic       [PROD_W-1:0]  prod_s3;
			logic       [R16_W-1:0]   den_s3;
			logic                     neg_s3;
			div_state_t               dv_s4;
			div_state_t               dv [DIV_CELLS+1];

			assign mag = sq_c[c][COORD_W-1] ? COORD_W'(-sq_c[c]) : COORD_W'(sq_c[c]);

			always_ff @(posedge clk) begin
				if (adv) begin
					prod_s3   <= PROD_W'(radius_q * mag);
					den_s3    <= r16;
					neg_s3    <= sq_c[c][COORD_W-1];
					dv_s4.rem <= DIV_REM_W'({prod_s3, 9'b0}) + DIV_REM_W'(den_s3);
					dv_s4.den <= den_s3;
					dv_s4.quo <= '0;
					dv_s4.neg <= neg_s3;
				end
			end

			assign dv[0] = dv_s4;

			for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cell
				psp_div_cell #(.SHIFT(DIV_CELLS - 1 - k)) u_cell (
					.clk(clk), .en(adv), .d(dv[k]), .q(dv[k+1])
				);
			end

			psp_delay #(.W(QUO_W + 1), .DEPTH(POST_LEN - DIV_LEN)) u_align (
				.clk(clk), .arst_n(arst_n), .en(adv),
				.d({dv[DIV_CELLS].neg, dv[DIV_CELLS].quo}),
				.q({neg_al[c], quo_al[c]})
			);
		end
	endgenerate

	// side data across the angle and divider rows
	logic               pv, pdeg;
	logic [RANGE_W-1:0] prange;

	psp_delay #(.W(2 + RANGE_W), .DEPTH(POST_LEN)) u_post_side (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.d({sq_v, sq_deg, r16[R16_W-1 -: RANGE_W]}),
		.q({pv, pdeg, prange})
	);

	// output register
	logic signed [AZ_W-1:0]    azimuth_q;
	logic        [POL_W-1:0]   polar_q;
	logic        [RANGE_W-1:0] range_q;
	logic signed [CLOSE_W-1:0] closeness_q;
	logic signed [SURF_W-1:0]  surf_q [3];
	logic                      deg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= pv;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			azimuth_q   <= pdeg ? '0 : az_al;
			polar_q     <= pdeg ? '0 : pol_al;
			range_q     <= prange;
			closeness_q <= $signed(CLOSE_W'(radius_q)) - $signed(CLOSE_W'(prange));
			deg_q       <= pdeg;
			for (int c = 0; c < 3; c++) begin
				surf_q[c] <= pdeg ? '0
					: (neg_al[c] ? -$signed(quo_al[c]) : $signed(quo_al[c]));
			end
		end
	end

	assign proj.valid       = out_valid_q;
	assign proj.azimuth     = azimuth_q;
	assign proj.polar_angle = polar_q;
	assign proj.range       = range_q;
	assign proj.closeness   = closeness_q;
	assign proj.surface_x   = surf_q[0];
	assign proj.surface_y   = surf_q[1];
	assign proj.surface_z   = surf_q[2];
	assign proj.degenerate  = deg_q;

endmodule

`default_nettype wire

FILE: design/psp_delay.sv
// register line that carries side data alongside the processing cells
`default_nettype none

module psp_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	generate
		if (DEPTH == 0) begin : g_none
			assign q = d;
		end else begin : g_line
			logic [W-1:0] stage_q [DEPTH];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					for (int i = 0; i < DEPTH; i++) stage_q[i] <= '0;
				end else if (en) begin
					stage_q[0] <= d;
					for (int i = 1; i < DEPTH; i++) stage_q[i] <= stage_q[i-1];
				end
			end

			assign q = stage_q[DEPTH-1];
		end
	endgenerate

endmodule

`default_nettype wire

FILE: design/psp_sqrt_cell.sv
// one digit of the restoring square root
`default_nettype none

module psp_sqrt_cell import psp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire sqrt_state_t d,
	output sqrt_state_t      q
);

	sqrt_state_t      state_q;
	sqrt_state_t      nxt;
	logic [REM_W-1:0] acc;
	logic [REM_W-1:0] trial;

	always_comb begin
		acc       = {d.rem[REM_W-3:0], d.rad[RAD_W-1 -: 2]};
		trial     = {2'b00, d.root, 2'b01};
		nxt.rad   = {d.rad[RAD_W-3:0], 2'b00};
		if (acc >= trial) begin
			nxt.rem  = acc - trial;
			nxt.root = {d.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = acc;
			nxt.root = {d.root[ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) state_q <= nxt;
	end

	assign q = state_q;

endmodule

`default_nettype wire

FILE: design/psp_cordic_cell.sv
// one vectoring rotation of the angle cordic
`default_nettype none

module psp_cordic_cell import psp_pkg::*; #(
	parameter int IDX = 0
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire cordic_vec_t d,
	output cordic_vec_t      q
);

	cordic_vec_t                state_q;
	cordic_vec_t                nxt;
	logic signed [CORDIC_W-1:0] px;
	logic signed [CORDIC_W-1:0] py;
	logic signed [CORDIC_W-1:0] shx;
	logic signed [CORDIC_W-1:0] shy;

	always_comb begin
		px  = d.px;
		py  = d.py;
		shx = px >>> IDX;
		shy = py >>> IDX;
		if (!py[CORDIC_W-1]) begin
			nxt.px  = px + shy;
			nxt.py  = py - shx;
			nxt.ang = d.ang + atan_q16(IDX);
		end else begin
			nxt.px  = px - shy;
			nxt.py  = py + shx;
			nxt.ang = d.ang - atan_q16(IDX);
		end
	end

	always_ff @(posedge clk) begin
		if (en) state_q <= nxt;
	end

	assign q = state_q;

endmodule

`default_nettype wire

FILE: design/psp_div_cell.sv
// one quotient bit of the restoring divider
`default_nettype none

module psp_div_cell import psp_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  wire logic       clk,
	input  wire logic       en,
	input  wire div_state_t d,
	output div_state_t      q
);

	div_state_t           state_q;
	div_state_t           nxt;
	logic [DIV_REM_W-1:0] dsh;

	always_comb begin
		dsh = DIV_REM_W'({d.den, 1'b0}) << SHIFT;
		nxt = d;
		if (d.rem >= dsh) begin
			nxt.rem        = d.rem - dsh;
			nxt.quo[SHIFT] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) state_q <= nxt;
	end

	assign q = state_q;

endmodule

`default_nettype wire

FILE: tb/point_spherical_projection_top_test.sv
// self-checking testbench of the spherical point projection
`default_nettype none

module point_spherical_projection_top_test;
	import psp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [15:0] azimuth;
		logic        [14:0] polar_angle;
		logic        [17:0] range;
		logic signed [18:0] closeness;
		logic signed [16:0] surface_x;
		logic signed [16:0] surface_y;
		logic signed [16:0] surface_z;
		logic               degenerate;
	} proj_t;

	typedef struct {
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [17:0] z;
		bit                 typed;
		proj_t              res;
	} point_row_t;

	localparam int LIMIT_CYCLES = 600000;
	localparam int TAIL_CYCLES  = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	psp_point_if point ();
	psp_proj_if proj ();

	point_spherical_projection_top u_top (
		.clk(clk), .arst_n(arst_n), .point(point.sink), .proj(proj.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	logic [15:0] radius_model;
	proj_t expected_q[$];
	int mismatches = 0;
	int cycles = 0;
	bit hold_off = 1'b0;
	bit stall_on = 1'b0;

	initial begin
		point.valid = 1'b0;
		point.point_x = '0;
		point.point_y = '0;
		point.point_z = '0;
		proj.ready = 1'b0;
	end

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned res = 0, bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint atan_angle(longint px, longint py);
		longint ang = 0, t, mag, nx, ny;
		if (px < 0) begin
			if (py >= 0) begin
				t = px; px = py; py = -t; ang = 102944;
			end else begin
				t = px; px = -py; py = t; ang = -102944;
			end
		end
		for (int i = 0; i < 16; i++) begin
			if (py >= 0) begin
				nx = px + floor_shr(py, i);
				ny = py - floor_shr(px, i);
				ang += atan_q16(i);
			end else begin
				nx = px - floor_shr(py, i);
				ny = py + floor_shr(px, i);
				ang -= atan_q16(i);
			end
			px = nx;
			py = ny;
		end
		mag = ((ang < 0 ? -ang : ang) + 4) >>> 3;
		if (mag > PI_Q13) mag = PI_Q13;
		return ang < 0 ? -mag : mag;
	endfunction

	function automatic longint round_div(longint num, longint den);
		longint m = num < 0 ? -num : num;
		longint q = (2 * m + den) / (2 * den);
		return num < 0 ? -q : q;
	endfunction

	function automatic proj_t project_point(longint x, longint y, longint z, longint rad);
		proj_t p;
		longint sxy = x * x + y * y;
		longint s = sxy + z * z;
		longint r16, rho, rng = 0, az = 0, pol = 0, sx = 0, sy = 0, sz = 0;
		p.degenerate = (s == 0);
		if (s != 0) begin
			r16 = int_sqrt(s << 16);
			rho = int_sqrt(sxy << 24);
			rng = r16 >>> 8;
			az = atan_angle(x * 4096, y * 4096);
			pol = atan_angle(z * 4096, rho);
			if (pol < 0) pol = 0;
			sx = round_div(rad * x * 256, r16);
			sy = round_div(rad * y * 256, r16);
			sz = round_div(rad * z * 256, r16);
		end
		p.azimuth = az[15:0];
		p.polar_angle = pol[14:0];
		p.range = rng[17:0];
		p.closeness = 19'(rad - rng);
		p.surface_x = sx[16:0];
		p.surface_y = sy[16:0];
		p.surface_z = sz[16:0];
		return p;
	endfunction

	function automatic void queue_result(proj_t p);
		expected_q.insert(expected_q.size(), p);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("error: %s got %0d expected %0d at cycle %0d", what, got, want, cycles);
		mismatches++;
	endtask

	// result checker
	always @(posedge clk) begin
		proj_t want;
		if (arst_n && proj.valid && proj.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected transaction", 0, 0);
			end else begin
				want = expected_q.pop_front();
				if (proj.azimuth !== want.azimuth)
					report_mismatch("azimuth", proj.azimuth, want.azimuth);
				if (proj.polar_angle !== want.polar_angle)
					report_mismatch("polar_angle", proj.polar_angle, want.polar_angle);
				if (proj.range !== want.range)
					report_mismatch("range", proj.range, want.range);
				if (proj.closeness !== want.closeness)
					report_mismatch("closeness", proj.closeness, want.closeness);
				if (proj.surface_x !== want.surface_x)
					report_mismatch("surface_x", proj.surface_x, want.surface_x);
				if (proj.surface_y !== want.surface_y)
					report_mismatch("surface_y", proj.surface_y, want.surface_y);
				if (proj.surface_z !== want.surface_z)
					report_mismatch("surface_z", proj.surface_z, want.surface_z);
				if (proj.degenerate !== want.degenerate)
					report_mismatch("degenerate", proj.degenerate, want.degenerate);
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (hold_off) proj.ready <= 1'b0;
		else if (!stall_on) proj.ready <= 1'b1;
		else proj.ready <= (r % 7) > 2;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout at cycle %0d", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic write_radius(logic [15:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= REG_SURFACE_RADIUS; pwdata <= {16'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		radius_model = value;
	endtask

	task automatic send_point(logic signed [17:0] x, logic signed [17:0] y,
		logic signed [17:0] z, bit typed, proj_t res);
		point.valid <= 1'b1;
		point.point_x <= x;
		point.point_y <= y;
		point.point_z <= z;
		do @(posedge clk); while (!point.ready);
		queue_result(typed ? res : project_point(x, y, z, radius_model));
	endtask

	task automatic drain;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [17:0] rand_coord(bit short);
		int k = $urandom_range(0, 9);
		if (k == 0) return $urandom_range(0, 1) ? 18'sh1ffff : -18'sh20000;
		if (short || k < 4) return 18'($signed($urandom_range(0, 64)) - 32);
		return 18'($urandom);
	endfunction

	task automatic random_burst(int count);
		int sent = 0;
		int len;
		while (sent < count) begin
			len = $urandom_range(1, 40);
			for (int i = 0; i < len && sent < count; i++) begin
				send_point(rand_coord(0), rand_coord($urandom_range(0, 3) == 0),
					rand_coord(0), 1'b0, '{default: '0});
				sent++;
			end
			if ($urandom_range(0, 2) != 0) begin
				point.valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		point.valid <= 1'b0;
	endtask

	point_row_t directed[$];
	logic [15:0] radius_steps[4] = '{16'd0, 16'd65535, 16'd1, 16'd777};

	function automatic void add_row(point_row_t row);
		directed.insert(directed.size(), row);
	endfunction

	initial begin
		proj_t origin;
		radius_model = RADIUS_RESET;
		origin = '{azimuth: 0, polar_angle: 0, range: 0, closeness: 2048,
			surface_x: 0, surface_y: 0, surface_z: 0, degenerate: 1};
		add_row('{0, 0, 0, 1, origin});
		add_row('{256, 0, 0, 0, origin});
		add_row('{0, 256, 0, 0, origin});
		add_row('{-256, 0, 0, 0, origin});
		add_row('{-5, 0, 7, 0, origin});
		add_row('{0, -256, 0, 0, origin});
		add_row('{0, 0, 256, 0, origin});
		add_row('{0, 0, -256, 0, origin});
		add_row('{18'sh1ffff, 18'sh1ffff, 18'sh1ffff, 0, origin});
		add_row('{-18'sh20000, -18'sh20000, -18'sh20000, 0, origin});
		add_row('{-18'sh20000, 0, 0, 0, origin});
		add_row('{1, 0, 0, 0, origin});
		add_row('{-1, -1, 1, 0, origin});
		add_row('{18'sh1ffff, -18'sh20000, 3, 0, origin});
		add_row('{-18'sh20000, -1, 0, 0, origin});
		add_row('{0, 0, 1, 0, origin});
		add_row('{100, -200, 300, 0, origin});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_point(directed[i].x, directed[i].y, directed[i].z, directed[i].typed,
				directed[i].res);
		point.valid <= 1'b0;
		drain();

		stall_on = 1'b1;
		random_burst(400);
		drain();

		foreach (radius_steps[s]) begin
			write_radius(radius_steps[s]);
			send_point(0, 0, 0, 1'b1, '{0, 0, 0, 19'(radius_steps[s]), 0, 0, 0, 1});
			stall_on = (s % 2) == 0;
			random_burst(350);
			drain();
		end

		// long receiver hold-off while points keep coming
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			random_burst(120);
		join
		drain();

		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: point_spherical_projection_top.f
design/psp_pkg.sv
design/psp_if.sv
design/psp_delay.sv
design/psp_sqrt_cell.sv
design/psp_cordic_cell.sv
design/psp_div_cell.sv
design/point_spherical_projection_top.sv
tb/point_spherical_projection_top_test.sv
